// ----- rtl/mrm_pkg.sv -----
package mrm_pkg;

    // Largest register count a read may ask for
    localparam int unsigned MAX_REGS_DEF = 32;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // Input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Operations
    localparam logic [1:0] OP_RD_HOLD  = 2'd0;
    localparam logic [1:0] OP_RD_INPUT = 2'd1;
    localparam logic [1:0] OP_WR_SINGLE = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    // Function codes
    localparam logic [7:0] FN_RD_HOLD   = 8'h03;
    localparam logic [7:0] FN_RD_INPUT  = 8'h04;
    localparam logic [7:0] FN_WR_SINGLE = 8'h06;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_CRC     = 3'd1;
    localparam logic [2:0] STS_COUNT   = 3'd2;
    localparam logic [2:0] STS_TIMEOUT = 3'd3;
    localparam logic [2:0] STS_BAD_REQ = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  operation;
        logic [7:0]  slave_id;
        logic [15:0] reg_address;
        logic [15:0] reg_count_or_value;
        logic [7:0]  rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [2:0]  status;
        logic        last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REQ_CRC,
        ST_SID_CRC,
        ST_TX,
        ST_RX_CRC,
        ST_CHECK,
        ST_WORD_RD,
        ST_WORD_OUT,
        ST_STATUS
    } state_t;

    // One bit step of the reflected Modbus CRC
    function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
        logic [15:0] sh;
        sh = {1'b0, crc[15:1]};
        return crc[0] ? (sh ^ CRC_POLY) : sh;
    endfunction

endpackage

// ----- rtl/modbus_rtu_master_transaction.sv -----
// Modbus RTU master engine. A start request (cmd 0) is checked, its CRC-16 is worked out one
// bit per cycle on a single shared CRC stepper (the six request bytes, then the slave id that
// seeds the response CRC), and the eight request bytes leave as kind-0 results; the next
// request can be taken only after the last of them, later while the consumer stalls. A
// received byte (cmd 1) enters the response CRC through the same stepper when the CRC covers
// it. The final byte of a response leads to the check, then to each register word read back
// from the word store, then to one status result. A tick (cmd 2) advances the timeout count
// and may end in a timeout status. The output register holds a result while the consumer
// stalls; the block stalls with it. s_ready is high only between items.
module modbus_rtu_master_transaction #(
    parameter int unsigned MAX_REGS = mrm_pkg::MAX_REGS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mrm_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output mrm_pkg::out_t  m_payload,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);

    localparam int unsigned AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int unsigned CW = $clog2(MAX_REGS + 1);
    localparam int unsigned LW = $clog2(2 * MAX_REGS + 9);

    mrm_pkg::state_t state_reg, state_next;

    logic [15:0]   tmo_reg, tmo_next;
    logic          busy_reg, busy_next;
    logic [1:0]    op_reg, op_next;
    logic [7:0]    slave_reg, slave_next;
    logic [15:0]   addr_reg, addr_next;
    logic [15:0]   cv_reg, cv_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   txcrc_reg, txcrc_next;
    logic [7:0]    bc_reg, bc_next;
    logic [7:0]    hi_reg, hi_next;
    logic [7:0]    crclo_reg, crclo_next;
    logic [7:0]    rxb_reg, rxb_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic [2:0]    bit_reg, bit_next;
    logic [2:0]    byte_reg, byte_next;
    logic [CW-1:0] word_reg, word_next;
    logic [2:0]    sts_reg, sts_next;

    logic          m_valid_reg, m_valid_next;
    mrm_pkg::out_t m_payload_reg, m_payload_next;

    logic [15:0]   mem [MAX_REGS];
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;
    logic [AW-1:0] mem_ra;

    logic          out_free;
    logic [7:0]    feed_byte;
    logic [15:0]   crc_step;
    logic [7:0]    req_byte;
    logic [LW-1:0] idx_wa;
    logic [15:0]   elapsed_inc;

    assign s_ready   = (state_reg == mrm_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Select the request byte under the byte counter
    always_comb begin
        case (byte_reg)
            3'd0: req_byte = slave_reg;
            3'd1: begin
                case (op_reg)
                    mrm_pkg::OP_RD_HOLD:  req_byte = mrm_pkg::FN_RD_HOLD;
                    mrm_pkg::OP_RD_INPUT: req_byte = mrm_pkg::FN_RD_INPUT;
                    default:              req_byte = mrm_pkg::FN_WR_SINGLE;
                endcase
            end
            3'd2: req_byte = addr_reg[15:8];
            3'd3: req_byte = addr_reg[7:0];
            3'd4: req_byte = cv_reg[15:8];
            3'd5: req_byte = cv_reg[7:0];
            3'd6: req_byte = txcrc_reg[7:0];
            default: req_byte = txcrc_reg[15:8];
        endcase
    end

    // Shared CRC stepper: fold the byte in on its first bit
    always_comb begin
        case (state_reg)
            mrm_pkg::ST_REQ_CRC: feed_byte = req_byte;
            mrm_pkg::ST_SID_CRC: feed_byte = slave_reg;
            default:             feed_byte = rxb_reg;
        endcase
        crc_step = mrm_pkg::crc_bit_step((bit_reg == 3'd0) ?
                                         (crc_reg ^ {8'h00, feed_byte}) : crc_reg);
    end

    assign idx_wa      = (idx_reg - LW'(3)) >> 1;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        tmo_next       = tmo_reg;
        busy_next      = busy_reg;
        op_next        = op_reg;
        slave_next     = slave_reg;
        addr_next      = addr_reg;
        cv_next        = cv_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        txcrc_next     = txcrc_reg;
        bc_next        = bc_reg;
        hi_next        = hi_reg;
        crclo_next     = crclo_reg;
        rxb_next       = rxb_reg;
        elapsed_next   = elapsed_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        word_next      = word_reg;
        sts_next       = sts_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_wa[AW-1:0];
        mem_wd         = {hi_reg, s_payload.rx_byte};
        mem_ra         = word_reg[AW-1:0];

        if (cfg_valid) begin
            tmo_next = cfg_data;
        end

        case (state_reg)
            mrm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_payload.cmd)
                        mrm_pkg::CMD_START: begin
                            busy_next = 1'b0;
                            if (s_payload.operation == mrm_pkg::OP_RESERVED ||
                                (s_payload.operation != mrm_pkg::OP_WR_SINGLE &&
                                 (s_payload.reg_count_or_value == 16'd0 ||
                                  s_payload.reg_count_or_value > 16'(MAX_REGS)))) begin
                                sts_next   = mrm_pkg::STS_BAD_REQ;
                                state_next = mrm_pkg::ST_STATUS;
                            end else begin
                                op_next      = s_payload.operation;
                                slave_next   = s_payload.slave_id;
                                addr_next    = s_payload.reg_address;
                                cv_next      = s_payload.reg_count_or_value;
                                if (s_payload.operation == mrm_pkg::OP_WR_SINGLE) begin
                                    count_next = '0;
                                    len_next   = LW'(8);
                                end else begin
                                    count_next = s_payload.reg_count_or_value[CW-1:0];
                                    len_next   = LW'(5) +
                                        {s_payload.reg_count_or_value[LW-2:0], 1'b0};
                                end
                                idx_next     = '0;
                                bc_next      = '0;
                                hi_next      = '0;
                                crclo_next   = '0;
                                elapsed_next = '0;
                                crc_next     = mrm_pkg::CRC_INIT;
                                bit_next     = '0;
                                byte_next    = '0;
                                busy_next    = 1'b1;
                                state_next   = mrm_pkg::ST_REQ_CRC;
                            end
                        end
                        mrm_pkg::CMD_BYTE: begin
                            if (busy_reg) begin
                                rxb_next = s_payload.rx_byte;
                                idx_next = idx_reg + LW'(1);
                                if (op_reg != mrm_pkg::OP_WR_SINGLE) begin
                                    if (idx_reg == LW'(2)) begin
                                        bc_next = s_payload.rx_byte;
                                    end
                                    if (idx_reg >= LW'(3) && idx_reg + LW'(3) <= len_reg) begin
                                        if (idx_reg[0]) begin
                                            hi_next = s_payload.rx_byte;
                                        end else begin
                                            mem_we = 1'b1;
                                        end
                                    end
                                end
                                if (idx_reg + LW'(2) == len_reg) begin
                                    crclo_next = s_payload.rx_byte;
                                end
                                if (idx_reg >= LW'(1) && idx_reg + LW'(3) <= len_reg) begin
                                    bit_next   = '0;
                                    state_next = mrm_pkg::ST_RX_CRC;
                                end else if (idx_reg + LW'(1) >= len_reg) begin
                                    busy_next  = 1'b0;
                                    state_next = mrm_pkg::ST_CHECK;
                                end
                            end
                        end
                        mrm_pkg::CMD_TICK: begin
                            if (busy_reg) begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= tmo_reg) begin
                                    busy_next  = 1'b0;
                                    sts_next   = mrm_pkg::STS_TIMEOUT;
                                    state_next = mrm_pkg::ST_STATUS;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Request CRC, one bit a cycle over six bytes
            mrm_pkg::ST_REQ_CRC: begin
                crc_next = crc_step;
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    byte_next = byte_reg + 3'd1;
                    if (byte_reg == 3'd5) begin
                        txcrc_next = crc_step;
                        crc_next   = mrm_pkg::CRC_INIT;
                        state_next = mrm_pkg::ST_SID_CRC;
                    end
                end
            end
            // Seed the response CRC with the slave id
            mrm_pkg::ST_SID_CRC: begin
                crc_next = crc_step;
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    byte_next  = '0;
                    state_next = mrm_pkg::ST_TX;
                end
            end
            mrm_pkg::ST_TX: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{kind: mrm_pkg::KIND_TX, data: {8'h00, req_byte},
                                       status: mrm_pkg::STS_OK, last: byte_reg == 3'd7};
                    byte_next      = byte_reg + 3'd1;
                    if (byte_reg == 3'd7) begin
                        state_next = mrm_pkg::ST_IDLE;
                    end
                end
            end
            mrm_pkg::ST_RX_CRC: begin
                crc_next = crc_step;
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    state_next = mrm_pkg::ST_IDLE;
                end
            end
            // Compare CRC, then byte count
            mrm_pkg::ST_CHECK: begin
                word_next = '0;
                if (crclo_reg != crc_reg[7:0] || rxb_reg != crc_reg[15:8]) begin
                    sts_next   = mrm_pkg::STS_CRC;
                    state_next = mrm_pkg::ST_STATUS;
                end else if (op_reg != mrm_pkg::OP_WR_SINGLE &&
                             bc_reg != 8'({count_reg, 1'b0})) begin
                    sts_next   = mrm_pkg::STS_COUNT;
                    state_next = mrm_pkg::ST_STATUS;
                end else if (op_reg != mrm_pkg::OP_WR_SINGLE) begin
                    sts_next   = mrm_pkg::STS_OK;
                    state_next = mrm_pkg::ST_WORD_RD;
                end else begin
                    sts_next   = mrm_pkg::STS_OK;
                    state_next = mrm_pkg::ST_STATUS;
                end
            end
            mrm_pkg::ST_WORD_RD: begin
                state_next = mrm_pkg::ST_WORD_OUT;
            end
            mrm_pkg::ST_WORD_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{kind: mrm_pkg::KIND_WORD, data: rd_data_reg,
                                       status: mrm_pkg::STS_OK, last: 1'b0};
                    word_next      = word_reg + CW'(1);
                    state_next     = (word_reg + CW'(1) == count_reg) ?
                                     mrm_pkg::ST_STATUS : mrm_pkg::ST_WORD_RD;
                end
            end
            mrm_pkg::ST_STATUS: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{kind: mrm_pkg::KIND_STATUS, data: 16'h0000,
                                       status: sts_reg, last: 1'b1};
                    state_next     = mrm_pkg::ST_IDLE;
                end
            end
            default: state_next = mrm_pkg::ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mrm_pkg::ST_IDLE;
            tmo_reg     <= mrm_pkg::TIMEOUT_RESET;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            op_reg      <= '0;
            idx_reg     <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            elapsed_reg <= '0;
            crc_reg     <= mrm_pkg::CRC_INIT;
            bit_reg     <= '0;
            byte_reg    <= '0;
            word_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            tmo_reg     <= tmo_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            crc_reg     <= crc_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            word_reg    <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        slave_reg     <= slave_next;
        addr_reg      <= addr_next;
        cv_reg        <= cv_next;
        txcrc_reg     <= txcrc_next;
        bc_reg        <= bc_next;
        hi_reg        <= hi_next;
        crclo_reg     <= crclo_next;
        rxb_reg       <= rxb_next;
        sts_reg       <= sts_next;
        m_payload_reg <= m_payload_next;
    end

    // Word store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

`ifndef SYNTHESIS
    a_words_only_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mrm_pkg::ST_WORD_OUT |-> op_reg != mrm_pkg::OP_WR_SINGLE)
        else $error("word output during a write transaction");
    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == mrm_pkg::KIND_STATUS |-> m_payload.last)
        else $error("status result not marked last");
    a_tx_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mrm_pkg::ST_TX |-> busy_reg)
        else $error("request bytes sent while not busy");
`endif

endmodule
